[hdl/stsg_pkg.sv]
// package for the sensor timestamp sanity gate
// holds condition and reset codes, register indexes and the queue entry type
package stsg_pkg;

    typedef enum logic [3:0] {
        COND_OK        = 4'd0,
        COND_TYPE_CHG  = 4'd1,
        COND_TOL_BACK  = 4'd2,
        COND_DROP_BACK = 4'd3,
        COND_BACK_JUMP = 4'd4,
        COND_FWD_JUMP  = 4'd5,
        COND_SYNC_ERR  = 4'd6,
        COND_NO_OFFSET = 4'd7,
        COND_FOREIGN   = 4'd8
    } t_cond;

    typedef enum logic [1:0] {
        RST_NONE = 2'd0,
        RST_SOFT = 2'd1,
        RST_HARD = 2'd2
    } t_rst;

    localparam logic [2:0] REG_SMALL_BACK = 3'd0;
    localparam logic [2:0] REG_FWD_JUMP   = 3'd1;
    localparam logic [2:0] REG_MISMATCH   = 3'd2;
    localparam logic [2:0] REG_HARD_JUMPS = 3'd3;
    localparam logic [2:0] REG_MISM_COUNT = 3'd4;

    // item as classified by the front end
    typedef struct packed {
        logic        empty;      // no samples, no state change
        logic        kind;
        logic [31:0] handle;
        logic [7:0]  time_code;
        logic [62:0] raw;
        logic        no_offset;
    } t_item;

    typedef struct packed {
        logic [31:0] small_back;
        logic [31:0] fwd_jump;
        logic [31:0] mismatch;
        logic [7:0]  hard_jumps;
        logic [7:0]  mism_count;
    } t_cfg;

endpackage

[hdl/stsg_front.sv]
// front end: accepts headers, classifies them and queues them for the back end
// depends on stsg_pkg; feeds stsg_back through a two entry queue
module stsg_front import stsg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [31:0] i_handle,
    input  logic [7:0]  i_time_code,
    input  logic [62:0] i_raw_timestamp_ns,
    input  logic [15:0] i_dot_count,
    input  logic [15:0] i_interval_raw,
    output logic        o_q_valid,
    output t_item       o_q_item,
    input  logic        i_q_pop
);
    t_item       r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        push;
    t_item       n_item;

    assign o_stall = (r_cnt == 2'd2);
    assign push    = i_valid && !o_stall;

    // classification
    always_comb begin
        n_item.kind      = i_kind;
        n_item.handle    = i_handle;
        n_item.time_code = i_time_code;
        n_item.raw       = i_raw_timestamp_ns;
        n_item.empty     = (i_dot_count == 16'd0);
        n_item.no_offset = (i_dot_count > 16'd1) && (i_interval_raw == 16'd0);
    end

    // two entry queue
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= n_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
        end
    end

    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rp];

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> r_cnt != 2'd0) else $error("queue underflow");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
`endif
endmodule

[hdl/stsg_back.sv]
// back end: active handle, timing checks against per stream state, result register
// depends on stsg_pkg; takes items from the front end queue
module stsg_back import stsg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_q_valid,
    input  t_item       i_q_item,
    output logic        o_q_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_accepted,
    output logic [63:0] o_normalized_ns,
    output logic [3:0]  o_condition,
    output logic [1:0]  o_reset_kind
);
    logic        r_act_v;
    logic [31:0] r_act_src;
    logic [31:0] r_owner;
    logic        r_ep_v;
    logic [62:0] r_ep;
    logic [1:0]  r_tv, r_lv;
    logic [7:0]  r_tc [2];
    logic [62:0] r_last [2];
    logic [7:0]  r_jrun, r_tcc;
    logic        r_ov;
    logic        r_acc;
    logic [63:0] r_norm;
    t_cond       r_cond;
    t_rst        r_rk;

    // per item working values
    logic        foreign;
    logic        clr, hard;
    logic        s;
    logic [1:0]  tv;
    logic [7:0]  tc0, tc1;
    logic [1:0]  lv;
    logic        ep_v;
    logic [62:0] ep;
    logic [7:0]  jrun, tcc;
    logic [63:0] last_s;
    logic [63:0] rawx, gap, step;
    t_cond       cond;
    t_rst        rk;
    logic        acc;
    logic        upd_last;
    logic        do_hard;
    logic [1:0]  n_lv;
    logic [62:0] n_last0, n_last1;

    assign o_q_pop = i_q_valid && (!r_ov || !i_stall);

    always_comb begin
        s        = i_q_item.kind;
        rawx     = {1'b0, i_q_item.raw};
        foreign  = i_q_item.empty ||
                   (s && r_act_v && i_q_item.handle != r_act_src);
        hard     = !s && r_act_v && i_q_item.handle != r_act_src;
        clr      = hard || (i_q_item.handle != r_owner);
        tv       = clr ? 2'b00 : r_tv;
        tc0      = clr ? 8'd0 : r_tc[0];
        tc1      = clr ? 8'd0 : r_tc[1];
        lv       = clr ? 2'b00 : r_lv;
        ep_v     = hard ? 1'b1 : (clr ? 1'b0 : r_ep_v);
        ep       = hard ? i_q_item.raw : (clr ? 63'd0 : r_ep);
        jrun     = clr ? 8'd0 : r_jrun;
        tcc      = clr ? 8'd0 : r_tcc;
        cond     = COND_OK;
        rk       = hard ? RST_HARD : RST_NONE;
        acc      = 1'b0;
        upd_last = 1'b0;
        do_hard  = 1'b0;
        last_s   = {1'b0, s ? r_last[1] : r_last[0]};
        gap      = (r_last[0] > r_last[1]) ? {1'b0, r_last[0] - r_last[1]}
                                            : {1'b0, r_last[1] - r_last[0]};
        step     = (rawx < last_s) ? last_s - rawx : rawx - last_s;
        // type tracking
        if (tv[s] && ((s ? tc1 : tc0) != i_q_item.time_code)) begin
            if (tcc != 8'hff) tcc = tcc + 8'd1;
            cond = COND_TYPE_CHG;
        end
        tv[s] = 1'b1;
        if (s) tc1 = i_q_item.time_code;
        else   tc0 = i_q_item.time_code;
        if (tv[0] && tv[1] && tc0 != tc1 && lv[0] && lv[1] &&
            gap > {32'd0, i_cfg.mismatch} && tcc >= i_cfg.mism_count) begin
            cond = COND_SYNC_ERR;
        end else begin
            if (!ep_v) begin
                ep_v = 1'b1;
                ep   = i_q_item.raw;
            end
            if (lv[s] && rawx < last_s && step <= {32'd0, i_cfg.small_back}) begin
                jrun = 8'd0;
                if (!s) cond = COND_DROP_BACK;
                else begin
                    cond = COND_TOL_BACK;
                    acc  = 1'b1;
                end
            end else if (lv[s] && (rawx < last_s ||
                         step > {32'd0, i_cfg.fwd_jump})) begin
                cond = (rawx < last_s) ? COND_BACK_JUMP : COND_FWD_JUMP;
                if (jrun != 8'hff) jrun = jrun + 8'd1;
                if (jrun >= i_cfg.hard_jumps) begin
                    do_hard = 1'b1;
                    rk      = RST_HARD;
                end else if (rk == RST_NONE) rk = RST_SOFT;
            end else begin
                if (lv[s]) jrun = 8'd0;
                acc = 1'b1;
            end
            if (acc) upd_last = !lv[s] || (rawx > last_s);
            if (acc && i_q_item.no_offset) begin
                cond = COND_NO_OFFSET;
                acc  = 1'b0;
            end
        end
        // next last-time state of both streams
        n_lv    = lv;
        n_last0 = clr ? 63'd0 : r_last[0];
        n_last1 = clr ? 63'd0 : r_last[1];
        if (upd_last) begin
            n_lv[s] = 1'b1;
            if (s) n_last1 = i_q_item.raw;
            else   n_last0 = i_q_item.raw;
        end
    end

    // active handle follows point packets and any hard reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_v   <= 1'b0;
            r_act_src <= 32'd0;
        end else if (o_q_pop && !foreign && (!s || do_hard)) begin
            r_act_v   <= 1'b1;
            r_act_src <= i_q_item.handle;
        end
    end

    // timing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owner <= 32'd0;
            r_ep_v  <= 1'b0;
            r_ep    <= 63'd0;
            r_tv    <= 2'b00;
            r_lv    <= 2'b00;
            r_tc[0] <= 8'd0;
            r_tc[1] <= 8'd0;
            r_last[0] <= 63'd0;
            r_last[1] <= 63'd0;
            r_jrun  <= 8'd0;
            r_tcc   <= 8'd0;
        end else if (o_q_pop && !foreign) begin
            r_owner <= i_q_item.handle;
            if (do_hard) begin
                r_ep_v    <= 1'b1;
                r_ep      <= i_q_item.raw;
                r_tv      <= 2'b00;
                r_lv      <= 2'b00;
                r_tc[0]   <= 8'd0;
                r_tc[1]   <= 8'd0;
                r_last[0] <= 63'd0;
                r_last[1] <= 63'd0;
                r_jrun    <= 8'd0;
                r_tcc     <= 8'd0;
            end else begin
                r_ep_v    <= ep_v;
                r_ep      <= ep;
                r_tv      <= tv;
                r_tc[0]   <= tc0;
                r_tc[1]   <= tc1;
                r_jrun    <= jrun;
                r_tcc     <= tcc;
                r_lv      <= n_lv;
                r_last[0] <= n_last0;
                r_last[1] <= n_last1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (o_q_pop) r_ov <= 1'b1;
        else if (!i_stall) r_ov <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            if (foreign) begin
                r_acc  <= 1'b0;
                r_norm <= 64'd0;
                r_cond <= COND_FOREIGN;
                r_rk   <= RST_NONE;
            end else begin
                r_acc  <= acc;
                r_norm <= acc ? rawx - {1'b0, ep} : 64'd0;
                r_cond <= cond;
                r_rk   <= rk;
            end
        end
    end

    assign o_valid         = r_ov;
    assign o_accepted      = r_acc;
    assign o_normalized_ns = r_norm;
    assign o_condition     = r_cond;
    assign o_reset_kind    = r_rk;

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && i_stall |=> r_ov && $stable(r_cond)) else $error("result lost");
    a_acc_cond: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_acc |-> (r_cond == COND_OK || r_cond == COND_TYPE_CHG ||
        r_cond == COND_TOL_BACK)) else $error("accepted with drop cause");
    a_norm_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !r_acc |-> r_norm == 64'd0) else $error("dropped with time");
`endif
endmodule

[hdl/stsg_regs.sv]
// configuration registers behind an apb-style port
// depends on stsg_pkg for register indexes and the config struct
module stsg_regs import stsg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);
    t_cfg       r_cfg;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];

    // register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.small_back <= 32'd5000000;
            r_cfg.fwd_jump   <= 32'd1000000000;
            r_cfg.mismatch   <= 32'd200000000;
            r_cfg.hard_jumps <= 8'd6;
            r_cfg.mism_count <= 8'd8;
        end else if (psel && penable && pwrite) begin
            unique case (idx)
                REG_SMALL_BACK: r_cfg.small_back <= pwdata;
                REG_FWD_JUMP:   r_cfg.fwd_jump   <= pwdata;
                REG_MISMATCH:   r_cfg.mismatch   <= pwdata;
                REG_HARD_JUMPS: r_cfg.hard_jumps <= pwdata[7:0];
                REG_MISM_COUNT: r_cfg.mism_count <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (idx)
            REG_SMALL_BACK: prdata = r_cfg.small_back;
            REG_FWD_JUMP:   prdata = r_cfg.fwd_jump;
            REG_MISMATCH:   prdata = r_cfg.mismatch;
            REG_HARD_JUMPS: prdata = {24'd0, r_cfg.hard_jumps};
            REG_MISM_COUNT: prdata = {24'd0, r_cfg.mism_count};
            default:        prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;
endmodule

[hdl/sensor_timestamp_sanity_gate_top.sv]
// sensor timestamp sanity gate: one header in, one verdict out
// the result is registered: an input passes a queue entry, then the result register
// throughput one item per cycle while not stalled; a two entry queue parts the front end
// from the timing back end, which handles one item per cycle unless the output stalls;
// input stalls while the queue is full; synchronous active-low reset restores register
// defaults and clears control and timing state, but not queue entries or result data
module sensor_timestamp_sanity_gate_top import stsg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [31:0] i_handle,
    input  logic [7:0]  i_time_code,
    input  logic [62:0] i_raw_timestamp_ns,
    input  logic [15:0] i_dot_count,
    input  logic [15:0] i_interval_raw,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_accepted,
    output logic signed [63:0] o_normalized_ns,
    output logic [3:0]  o_condition,
    output logic [1:0]  o_reset_kind
);
    t_cfg  cfg;
    logic  q_valid, q_pop;
    t_item q_item;
    logic [63:0] norm;

    stsg_regs u_regs (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .o_cfg(cfg)
    );

    stsg_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_kind, .i_handle, .i_time_code,
        .i_raw_timestamp_ns, .i_dot_count, .i_interval_raw,
        .o_q_valid(q_valid), .o_q_item(q_item), .i_q_pop(q_pop)
    );

    stsg_back u_back (
        .i_clk, .i_rst_n, .i_cfg(cfg), .i_q_valid(q_valid), .i_q_item(q_item),
        .o_q_pop(q_pop), .o_valid, .i_stall, .o_accepted,
        .o_normalized_ns(norm), .o_condition, .o_reset_kind
    );

    assign o_normalized_ns = $signed(norm);
endmodule
